FILE: rtl/core/ppi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg: shared definitions of the planar pose integrator
// CORDIC step count, word widths, arctangent table and unit status type.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS_EFF    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(STEPS_EFF + 1);
  localparam int ATAN_IDX_W   = 5;

  // cordic datapath width, q2.30 plus guard bits
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(34'sh026DD3B6A);

  typedef struct packed {
    logic busy;
    logic done;
  } ppi_cordic_stat_t;

  // atan(2^-i), 2^32 = full turn
  function automatic logic [31:0] atan_phase(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/planar_pose_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Integrate item: the elapsed-time multiply runs beside the 16-step CORDIC, then
// the bit-serial rotation multiply, rounding, pose update and result register follow.
// Load item: the pose is set, then the result is registered once the output is free.
// One item at a time; the next transfer is taken once the result is registered.
// Synchronous active-low reset clears the pose to zero and empties the output.
// ----------------------------------------------------------------------------
// planar_pose_integrator_core: dead-reckoning pose integrator
// Rotates body velocity by the heading, scales by elapsed time and updates
// a saturating position and a modular binary-angle heading.
// ----------------------------------------------------------------------------
module planar_pose_integrator_core
  import ppi_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_command,
  input  wire  signed [15:0] in_vel_x,
  input  wire  signed [15:0] in_vel_y,
  input  wire  signed [23:0] in_yaw_rate,
  input  wire         [15:0] in_elapsed,
  input  wire  signed [31:0] in_set_x,
  input  wire  signed [31:0] in_set_y,
  input  wire         [15:0] in_set_heading,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic        [15:0] out_pose_heading
);

  localparam int DT_W    = 16;
  localparam int VD_W    = 32;
  localparam int HW      = CW + 2;
  localparam int RND_LSB = 41 - VD_W;
  localparam int RW      = HW - RND_LSB;
  localparam int SW      = 34;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL1   = 6'b000010,
    ST_MUL2   = 6'b000100,
    ST_ROUND  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [15:0]        heading_r, heading_nxt;

  logic [4:0]         cnt_r, cnt_nxt;
  logic [DT_W-1:0]    dt_sr_r, dt_sr_nxt;
  logic [VD_W-1:0]    vx_sh_r, vx_sh_nxt;
  logic [VD_W-1:0]    vy_sh_r, vy_sh_nxt;
  logic [31:0]        yaw_sh_r, yaw_sh_nxt;
  logic [VD_W-1:0]    vxd_r, vxd_nxt;
  logic [VD_W-1:0]    vyd_r, vyd_nxt;
  logic [31:0]        yd_r, yd_nxt;

  logic signed [HW-1:0] hi_x_r, hi_x_nxt;
  logic signed [HW-1:0] hi_y_r, hi_y_nxt;
  logic [VD_W-1:0]      lo_x_r, lo_x_nxt;
  logic [VD_W-1:0]      lo_y_r, lo_y_nxt;

  logic signed [RW-1:0] dx_r, dx_nxt;
  logic signed [RW-1:0] dy_r, dy_nxt;
  logic [15:0]          dh_r, dh_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   out_x_r, out_x_nxt;
  logic signed [31:0]   out_y_r, out_y_nxt;
  logic [15:0]          out_h_r, out_h_nxt;

  logic                 in_xfer;
  logic                 out_free;
  logic                 cordic_start;
  ppi_cordic_stat_t     cst;
  logic signed [CW-1:0] c_v, s_v, ns_v, cms_v, cps_v;

  logic                 last_bit;
  logic signed [CW-1:0] term_x, term_y;
  logic signed [HW-1:0] term_xe, term_ye;
  logic signed [HW-1:0] sum_x, sum_y;
  logic signed [RW-1:0] rnd_x, rnd_y;
  logic [16:0]          rnd_h;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [RW-1:0] d);
    logic signed [SW-1:0] s;
    s = {{(SW-32){p[31]}}, p} + {{(SW-RW){d[RW-1]}}, d};
    if (s[SW-1:31] == '0 || s[SW-1:31] == '1) begin
      return s[31:0];
    end
    return s[SW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  assign in_stall     = (state_r != ST_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign cordic_start = in_xfer && !in_command;

  ppi_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cordic_start),
    .heading  (heading_r),
    .stat     (cst),
    .cos_val  (c_v),
    .sin_val  (s_v),
    .nsin_val (ns_v),
    .cms_val  (cms_v),
    .cps_val  (cps_v)
  );

  // partial product selection for the serial rotate
  assign last_bit = (cnt_r == 5'(VD_W - 1));

  always_comb begin
    case ({vxd_r[0], vyd_r[0]})
      2'b10:   term_x = c_v;
      2'b01:   term_x = ns_v;
      2'b11:   term_x = cms_v;
      default: term_x = '0;
    endcase
    case ({vxd_r[0], vyd_r[0]})
      2'b10:   term_y = s_v;
      2'b01:   term_y = c_v;
      2'b11:   term_y = cps_v;
      default: term_y = '0;
    endcase
  end

  assign term_xe = {{(HW-CW){term_x[CW-1]}}, term_x};
  assign term_ye = {{(HW-CW){term_y[CW-1]}}, term_y};
  assign sum_x   = last_bit ? (hi_x_r - term_xe) : (hi_x_r + term_xe);
  assign sum_y   = last_bit ? (hi_y_r - term_ye) : (hi_y_r + term_ye);

  assign rnd_x = hi_x_r[HW-1:RND_LSB] + RW'(1);
  assign rnd_y = hi_y_r[HW-1:RND_LSB] + RW'(1);
  assign rnd_h = yd_r[31:15] + 17'd1;

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    cnt_nxt       = cnt_r;
    dt_sr_nxt     = dt_sr_r;
    vx_sh_nxt     = vx_sh_r;
    vy_sh_nxt     = vy_sh_r;
    yaw_sh_nxt    = yaw_sh_r;
    vxd_nxt       = vxd_r;
    vyd_nxt       = vyd_r;
    yd_nxt        = yd_r;
    hi_x_nxt      = hi_x_r;
    hi_y_nxt      = hi_y_r;
    lo_x_nxt      = lo_x_r;
    lo_y_nxt      = lo_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dh_nxt        = dh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_h_nxt     = out_h_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_command) begin
            pos_x_nxt   = in_set_x;
            pos_y_nxt   = in_set_y;
            heading_nxt = in_set_heading;
            state_nxt   = ST_DONE;
          end else begin
            cnt_nxt    = '0;
            dt_sr_nxt  = in_elapsed;
            vx_sh_nxt  = {{(VD_W-16){in_vel_x[15]}}, in_vel_x};
            vy_sh_nxt  = {{(VD_W-16){in_vel_y[15]}}, in_vel_y};
            yaw_sh_nxt = {{8{in_yaw_rate[23]}}, in_yaw_rate};
            vxd_nxt    = '0;
            vyd_nxt    = '0;
            yd_nxt     = '0;
            state_nxt  = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        // one elapsed-time bit per cycle into three accumulators
        if (cnt_r != 5'(DT_W)) begin
          if (dt_sr_r[0]) begin
            vxd_nxt = vxd_r + vx_sh_r;
            vyd_nxt = vyd_r + vy_sh_r;
            yd_nxt  = yd_r + yaw_sh_r;
          end
          dt_sr_nxt  = {1'b0, dt_sr_r[DT_W-1:1]};
          vx_sh_nxt  = {vx_sh_r[VD_W-2:0], 1'b0};
          vy_sh_nxt  = {vy_sh_r[VD_W-2:0], 1'b0};
          yaw_sh_nxt = {yaw_sh_r[30:0], 1'b0};
          cnt_nxt    = cnt_r + 5'd1;
        end else if (!cst.busy) begin
          cnt_nxt   = '0;
          hi_x_nxt  = '0;
          hi_y_nxt  = '0;
          lo_x_nxt  = '0;
          lo_y_nxt  = '0;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        // one bit of the scaled velocities per cycle, sign bit last
        hi_x_nxt = {sum_x[HW-1], sum_x[HW-1:1]};
        hi_y_nxt = {sum_y[HW-1], sum_y[HW-1:1]};
        lo_x_nxt = {sum_x[0], lo_x_r[VD_W-1:1]};
        lo_y_nxt = {sum_y[0], lo_y_r[VD_W-1:1]};
        vxd_nxt  = {1'b0, vxd_r[VD_W-1:1]};
        vyd_nxt  = {1'b0, vyd_r[VD_W-1:1]};
        cnt_nxt  = cnt_r + 5'd1;
        if (last_bit) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        dx_nxt    = {rnd_x[RW-1], rnd_x[RW-1:1]};
        dy_nxt    = {rnd_y[RW-1], rnd_y[RW-1:1]};
        dh_nxt    = rnd_h[16:1];
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        pos_x_nxt   = sat_add(pos_x_r, dx_r);
        pos_y_nxt   = sat_add(pos_y_r, dy_r);
        heading_nxt = heading_r + dh_r;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pos_x_r;
          out_y_nxt     = pos_y_r;
          out_h_nxt     = heading_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r    <= cnt_nxt;
    dt_sr_r  <= dt_sr_nxt;
    vx_sh_r  <= vx_sh_nxt;
    vy_sh_r  <= vy_sh_nxt;
    yaw_sh_r <= yaw_sh_nxt;
    vxd_r    <= vxd_nxt;
    vyd_r    <= vyd_nxt;
    yd_r     <= yd_nxt;
    hi_x_r   <= hi_x_nxt;
    hi_y_r   <= hi_y_nxt;
    lo_x_r   <= lo_x_nxt;
    lo_y_r   <= lo_y_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    dh_r     <= dh_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_h_r  <= out_h_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = out_x_r;
  assign out_pose_y       = out_y_r;
  assign out_pose_heading = out_h_r;

  // the rotate multiply only runs on settled cordic results
  a_cordic_idle_mul2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL2) |-> !cst.busy)
    else $error("cordic busy during rotate multiply");

  a_cordic_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cst.busy)
    else $error("cordic busy while idle");

  a_done_publish: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid && (out_pose_heading == heading_r)))
    else $error("result not published on free output");

  a_load_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_command) |=> (heading_r == $past(in_set_heading)))
    else $error("load transfer did not set heading");

endmodule
`default_nettype wire

FILE: rtl/core/ppi_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_cordic: iterative sine and cosine of the heading
// One rotation step per cycle, then a finishing cycle that applies the
// half-turn flip and forms the sums and differences used by the multiplier.
// ----------------------------------------------------------------------------
module ppi_cordic
  import ppi_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire  [15:0]            heading,
  output ppi_cordic_stat_t       stat,
  output logic signed [CW-1:0]   cos_val,
  output logic signed [CW-1:0]   sin_val,
  output logic signed [CW-1:0]   nsin_val,
  output logic signed [CW-1:0]   cms_val,
  output logic signed [CW-1:0]   cps_val
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 flip_r, flip_nxt;
  logic [STEP_W-1:0]    i_r, i_nxt;
  logic signed [CW-1:0] x_r, x_nxt;
  logic signed [CW-1:0] y_r, y_nxt;
  logic signed [CW-1:0] z_r, z_nxt;

  logic signed [15:0]   h_s;
  logic                 flip_in;
  logic [15:0]          a16;
  logic signed [CW-1:0] dx, dy, dz;

  assign h_s     = heading;
  assign flip_in = (h_s > 16'sd16384) || (h_s < -16'sd16384);
  assign a16     = flip_in ? (heading + 16'h8000) : heading;

  assign dx = x_r >>> i_r;
  assign dy = y_r >>> i_r;
  assign dz = {{(CW-32){1'b0}}, atan_phase(ATAN_IDX_W'(i_r))};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      flip_nxt = flip_in;
      i_nxt    = '0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = {{(CW-32){a16[15]}}, a16, 16'h0000};
    end else if (busy_r) begin
      if (i_r == STEP_W'(STEPS_EFF)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        i_nxt = i_r + STEP_W'(1);
        if (!z_r[CW-1]) begin
          x_nxt = x_r - dy;
          y_nxt = y_r + dx;
          z_nxt = z_r - dz;
        end else begin
          x_nxt = x_r + dy;
          y_nxt = y_r - dx;
          z_nxt = z_r + dz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    flip_r <= flip_nxt;
    i_r    <= i_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  // results, flipped back by a half turn where needed
  always_ff @(posedge clk) begin
    if (busy_r && (i_r == STEP_W'(STEPS_EFF))) begin
      cos_val  <= flip_r ? -x_r : x_r;
      sin_val  <= flip_r ? -y_r : y_r;
      nsin_val <= flip_r ? y_r : -y_r;
      cms_val  <= flip_r ? (y_r - x_r) : (x_r - y_r);
      cps_val  <= flip_r ? (-x_r - y_r) : (x_r + y_r);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

FILE: verif/ppi_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pose_checker: pose prediction and result comparison
// Watches both channels of the pose integrator, predicts the pose after every
// input transfer and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
package ppi_tb_pkg;

  typedef enum logic {
    CMD_INTEGRATE = 1'b0,
    CMD_LOAD      = 1'b1
  } ppi_cmd_t;

endpackage

module ppi_pose_checker
  import ppi_pkg::*;
  import ppi_tb_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  wire                in_command,
  input  wire  signed [15:0] in_vel_x,
  input  wire  signed [15:0] in_vel_y,
  input  wire  signed [23:0] in_yaw_rate,
  input  wire         [15:0] in_elapsed,
  input  wire  signed [31:0] in_set_x,
  input  wire  signed [31:0] in_set_y,
  input  wire         [15:0] in_set_heading,
  input  wire                out_valid,
  input  wire                out_stall,
  input  wire  signed [31:0] out_pose_x,
  input  wire  signed [31:0] out_pose_y,
  input  wire         [15:0] out_pose_heading,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] h;
  } pose_t;

  localparam int     ATAN_LEN  = 24;
  localparam int     ROT_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam longint GAIN_Q30  = 64'sh26DD3B6A;
  localparam longint QUARTER   = 64'sh40000000;
  localparam longint ROUND_POS = 64'sh200_0000_0000;
  localparam longint ROUND_HDG = 64'sh8000;

  // arctangent of 2^-i, full turn = 2^32
  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  pose_t track;
  pose_t pose_q[$];
  int    errs      = 0;
  int    n_checked = 0;

  function automatic void heading_sin_cos(input logic [15:0] hdg, output longint c,
                                          output longint s);
    logic [31:0] phase;
    longint      a, x, y, z, dx, dy;
    bit          flip;
    phase = {hdg, 16'h0000};
    a     = longint'($signed(phase));
    flip  = 1'b0;
    // fold the back half-plane by half a turn
    if (a > QUARTER || a < -QUARTER) begin
      flip = 1'b1;
      a    = longint'($signed(phase - 32'h80000000));
    end
    x = GAIN_Q30;
    y = 0;
    z = a;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURN[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p, input longint d);
    longint r;
    r = longint'(p) + d;
    if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  function automatic pose_t advance_pose(input pose_t cur, input logic cmd,
                                         input logic signed [15:0] vx_in,
                                         input logic signed [15:0] vy_in,
                                         input logic signed [23:0] yaw_in,
                                         input logic        [15:0] dt_in,
                                         input logic signed [31:0] sx,
                                         input logic signed [31:0] sy,
                                         input logic        [15:0] sh);
    pose_t  nxt;
    longint c, s, vx, vy, yaw, dt, tx, ty, dh;
    if (cmd == CMD_LOAD) begin
      nxt.x = sx;
      nxt.y = sy;
      nxt.h = sh;
    end else begin
      heading_sin_cos(cur.h, c, s);
      vx    = vx_in;
      vy    = vy_in;
      yaw   = yaw_in;
      dt    = dt_in;
      tx    = vx * c - vy * s;
      ty    = vx * s + vy * c;
      nxt.x = sat_add(cur.x, (tx * dt + ROUND_POS) >>> 42);
      nxt.y = sat_add(cur.y, (ty * dt + ROUND_POS) >>> 42);
      dh    = (yaw * dt + ROUND_HDG) >>> 16;
      nxt.h = cur.h + dh[15:0];
    end
    return nxt;
  endfunction

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      track = '0;
      pose_q.delete();
    end else begin
      // result side first: a result never belongs to a same-edge input transfer
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $error("result transfer with no pose expected: x %0d y %0d heading %0d",
                 out_pose_x, out_pose_y, out_pose_heading);
          errs++;
        end else begin
          want = pose_q.pop_front();
          n_checked++;
          if (out_pose_x !== want.x) begin
            $error("pose_x mismatch: expected %0d, actual %0d", want.x, out_pose_x);
            errs++;
          end
          if (out_pose_y !== want.y) begin
            $error("pose_y mismatch: expected %0d, actual %0d", want.y, out_pose_y);
            errs++;
          end
          if (out_pose_heading !== want.h) begin
            $error("pose_heading mismatch: expected %0d, actual %0d", want.h,
                   out_pose_heading);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        track = advance_pose(track, in_command, in_vel_x, in_vel_y, in_yaw_rate,
                             in_elapsed, in_set_x, in_set_y, in_set_heading);
        pose_q.push_back(track);
      end
    end
    fail_count <= errs;
    pending    <= pose_q.size();
    checked    <= n_checked;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the planar pose integrator
// Drives directed and random integrate and load transfers under four pacing
// phases, with the pose checker alongside, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import ppi_tb_pkg::*;
();

  localparam int QUIET_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 420;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [15:0] TURN_EDGES [7] = '{
    16'h4000, 16'h4001, 16'h7FFF, 16'h8001, 16'hBFFF, 16'hC000, 16'hFFFF
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic signed [15:0] in_vel_x;
  logic signed [15:0] in_vel_y;
  logic signed [23:0] in_yaw_rate;
  logic        [15:0] in_elapsed;
  logic signed [31:0] in_set_x;
  logic signed [31:0] in_set_y;
  logic        [15:0] in_set_heading;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pose_x;
  logic signed [31:0] out_pose_y;
  logic        [15:0] out_pose_heading;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int n_moves       = 0;
  int n_loads       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  planar_pose_integrator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_yaw_rate      (in_yaw_rate),
    .in_elapsed       (in_elapsed),
    .in_set_x         (in_set_x),
    .in_set_y         (in_set_y),
    .in_set_heading   (in_set_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_heading (out_pose_heading)
  );

  ppi_pose_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_yaw_rate      (in_yaw_rate),
    .in_elapsed       (in_elapsed),
    .in_set_x         (in_set_x),
    .in_set_y         (in_set_y),
    .in_set_heading   (in_set_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_heading (out_pose_heading),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [31:0] edge_biased(input int unsigned w);
    logic [31:0] mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
    case ($urandom_range(0, 9))
      0:       edge_biased = '0;
      1:       edge_biased = mask >> 1;
      2:       edge_biased = 32'h1 << (w - 1);
      3:       edge_biased = mask;
      default: edge_biased = $urandom & mask;
    endcase
  endfunction

  // half of the positions lie within one maximal step of the rails, so saturation is reached
  function automatic logic [31:0] near_rail();
    case ($urandom_range(0, 3))
      0:       near_rail = 32'h7FFF_FFFF - $urandom_range(0, 600000);
      1:       near_rail = 32'h8000_0000 + $urandom_range(0, 600000);
      default: near_rail = $urandom;
    endcase
  endfunction

  task automatic send_item(input ppi_cmd_t cmd, input logic [15:0] vx, input logic [15:0] vy,
                           input logic [23:0] yaw, input logic [15:0] dt,
                           input logic [31:0] sx, input logic [31:0] sy,
                           input logic [15:0] sh);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_vel_x       <= vx;
    in_vel_y       <= vy;
    in_yaw_rate    <= yaw;
    in_elapsed     <= dt;
    in_set_x       <= sx;
    in_set_y       <= sy;
    in_set_heading <= sh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_LOAD) n_loads++;
    else n_moves++;
  endtask

  task automatic send_random();
    ppi_cmd_t cmd;
    cmd = ($urandom_range(0, 6) == 0) ? CMD_LOAD : CMD_INTEGRATE;
    send_item(cmd, 16'(edge_biased(16)), 16'(edge_biased(16)), 24'(edge_biased(24)),
              16'(edge_biased(16)), near_rail(), near_rail(), 16'(edge_biased(16)));
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_INTEGRATE;
    in_vel_x       <= '0;
    in_vel_y       <= '0;
    in_yaw_rate    <= '0;
    in_elapsed     <= '0;
    in_set_x       <= '0;
    in_set_y       <= '0;
    in_set_heading <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset pose, extreme fields, ignored fields, zero time step
    send_item(CMD_INTEGRATE, 16'h7FFF, 16'h0000, 24'h000000, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_item(CMD_INTEGRATE, 16'h8000, 16'h8000, 24'h7FFFFF, 16'hFFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(CMD_INTEGRATE, 16'h7FFF, 16'h7FFF, 24'h800000, 16'hFFFF,
              32'h8000_0000, 32'h0, 16'h8000);
    send_item(CMD_INTEGRATE, 16'h1234, 16'h4321, 24'h123456, 16'h0000, 32'h0, 32'h0, 16'h0);
    // load near the rails, then run into saturation and stay there
    send_item(CMD_LOAD, 16'h7FFF, 16'h8000, 24'h7FFFFF, 16'hFFFF,
              32'h7FFF_0000, 32'h8001_0000, 16'h0000);
    send_item(CMD_INTEGRATE, 16'h7FFF, 16'h8000, 24'h000000, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_item(CMD_INTEGRATE, 16'h7FFF, 16'h8000, 24'h000000, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_item(CMD_LOAD, 16'h0, 16'h0, 24'h0, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
    send_item(CMD_INTEGRATE, 16'h7FFF, 16'h8000, 24'h400000, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    // headings on the quarter-turn fold and wrap points
    for (int i = 0; i < 7; i++) begin
      send_item(CMD_LOAD, 16'h0, 16'h0, 24'h0, 16'h0, 32'h0, 32'h0, TURN_EDGES[i]);
      send_item(CMD_INTEGRATE, 16'h4E20, 16'hCFC7, 24'h3FFFFF, 16'h8000, 32'h0, 32'h0, 16'h0);
    end

    // pacing phases: free-running, sender gaps, back-pressure, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 50; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 50; end
        default: begin send_idle_pct = 32; stall_pct <= 32; end
      endcase
      repeat (RANDOM_ITEMS) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pose integrations and %0d pose loads, %0d results compared",
             n_moves, n_loads, checked);
    $display("pacing: free-running, sender gaps, receiver back-pressure, and both at once");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ppi_pkg.sv
rtl/core/ppi_cordic.sv
rtl/core/planar_pose_integrator_core.sv
verif/ppi_pose_checker.sv
verif/tb_top.sv
